@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on the rising edge and
// disabled while the active-low reset is asserted
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge
`define PSG_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// consequent holds in the cycle after the antecedent
`define PSG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/psg_pkg.sv @@
// ----------------------------------------------------------------------------
// psg_pkg
// shared types, widths, constants and tables of the pointer shake detector
// ----------------------------------------------------------------------------
package psg_pkg;

	localparam int WINDOW_DEPTH = 96;
	localparam int COORD_BITS   = 16;
	localparam int POS_W        = 16;
	localparam int TIME_W       = 32;
	localparam int CFG_W        = 16;
	localparam int SIZE_W       = 8;
	localparam int LEVEL_W      = 3;
	localparam int IDX_W        = 3;

	localparam int AW     = $clog2(WINDOW_DEPTH);
	localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
	localparam int CEXT_W = (COORD_BITS < POS_W) ? COORD_BITS : POS_W;

	localparam int D_W      = POS_W + 1;
	localparam int P_W      = 2 * D_W;
	localparam int V_W      = P_W + 2;
	localparam int SQ_FRAC  = 16;
	localparam int RAD_W    = 2 * D_W - 1 + SQ_FRAC;
	localparam int ROOT_W   = (RAD_W + 1) / 2;
	localparam int CR_W     = V_W + 2;
	localparam int Z_W      = 20;
	localparam int STEP_W   = 5;
	localparam int RTRIP_W  = D_W + CNT_W;
	localparam int CTRIP_W  = ROOT_W + CNT_W;
	localparam int NET_W    = Z_W + CNT_W + 1;
	localparam int MC_W     = 4;

	localparam int CORDIC_STEPS   = 17;
	localparam int ANG_HALF_PI    = 102944;
	localparam int ANG_MIN_TURN   = 7864;
	localparam int ANG_ARC_NEEDED = 308831;
	localparam int MIN_BIG        = 10;
	localparam int MIN_SEG_SQ     = 16;
	localparam int SPAN_MIN       = 35;
	localparam int REV_MIN_COUNT  = 5;
	localparam int CIRC_MIN_COUNT = 8;
	localparam int MIN_TURNS      = 5;
	localparam int MIN_FLIPS      = 3;
	localparam int MUL_LAST       = 8;

	localparam logic [CNT_W-1:0]   DEPTH_CNT = CNT_W'(WINDOW_DEPTH);
	localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(4);

	typedef enum logic [IDX_W-1:0] {
		REG_WINDOW_MS   = 3'd0,
		REG_COOLDOWN_MS = 3'd1,
		REG_DECAY_MS    = 3'd2,
		REG_MIN_PATH    = 3'd3,
		REG_SIZE_ONE    = 3'd4,
		REG_SIZE_TWO    = 3'd5,
		REG_SIZE_THREE  = 3'd6,
		REG_SIZE_FOUR   = 3'd7
	} cfg_reg_t;

	typedef enum logic {
		OP_SAMPLE = 1'b0,
		OP_TICK   = 1'b1
	} op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EVICT_RD,
		S_EVICT_CHK,
		S_PT_RD,
		S_PT_GET,
		S_NEXT,
		S_MUL,
		S_CHK,
		S_SQW,
		S_CRW,
		S_FIN1,
		S_FIN2,
		S_UPD
	} state_t;

	typedef struct packed {
		logic                   we;
		logic [AW-1:0]          addr;
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic [TIME_W-1:0]      t;
	} store_wr_t;

	function automatic logic [Z_W-1:0] atan_q16(input logic [STEP_W-1:0] k);
		logic [Z_W-1:0] a;
		case (k)
			5'd0:    a = Z_W'(51472);
			5'd1:    a = Z_W'(30385);
			5'd2:    a = Z_W'(16055);
			5'd3:    a = Z_W'(8150);
			5'd4:    a = Z_W'(4091);
			5'd5:    a = Z_W'(2047);
			5'd6:    a = Z_W'(1024);
			5'd7:    a = Z_W'(512);
			5'd8:    a = Z_W'(256);
			5'd9:    a = Z_W'(128);
			5'd10:   a = Z_W'(64);
			5'd11:   a = Z_W'(32);
			5'd12:   a = Z_W'(16);
			5'd13:   a = Z_W'(8);
			5'd14:   a = Z_W'(4);
			5'd15:   a = Z_W'(2);
			5'd16:   a = Z_W'(1);
			default: a = '0;
		endcase
		return a;
	endfunction

	function automatic logic [AW-1:0] slot_add(input logic [AW-1:0] h,
			input logic [CNT_W-1:0] k);
		logic [AW+1:0] s;
		s = (AW+2)'(h) + (AW+2)'(k);
		if (s >= (AW+2)'(WINDOW_DEPTH)) begin
			s = s - (AW+2)'(WINDOW_DEPTH);
		end
		return s[AW-1:0];
	endfunction

	function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] h);
		logic [AW-1:0] n;
		n = (h == AW'(WINDOW_DEPTH - 1)) ? '0 : h + AW'(1);
		return n;
	endfunction

	function automatic logic signed [POS_W-1:0] coord_ext(input logic [POS_W-1:0] raw);
		logic signed [POS_W-1:0] v;
		v = $signed(raw << (POS_W - CEXT_W)) >>> (POS_W - CEXT_W);
		return v;
	endfunction

endpackage

@@ rtl/psg_store.sv @@
// ----------------------------------------------------------------------------
// psg_store
// sample window memory: x, y and time per entry, one write and one
// registered read per cycle
// ----------------------------------------------------------------------------
module psg_store (
	input  logic                            clk,
	input  psg_pkg::store_wr_t              wr,
	input  logic [psg_pkg::AW-1:0]          rd_addr,
	output logic signed [psg_pkg::POS_W-1:0] rd_x,
	output logic signed [psg_pkg::POS_W-1:0] rd_y,
	output logic [psg_pkg::TIME_W-1:0]      rd_t
);

	logic [psg_pkg::POS_W-1:0]  mem_x [psg_pkg::WINDOW_DEPTH];
	logic [psg_pkg::POS_W-1:0]  mem_y [psg_pkg::WINDOW_DEPTH];
	logic [psg_pkg::TIME_W-1:0] mem_t [psg_pkg::WINDOW_DEPTH];
	logic [psg_pkg::POS_W-1:0]  x_q;
	logic [psg_pkg::POS_W-1:0]  y_q;

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem_x[wr.addr] <= wr.x;
			mem_y[wr.addr] <= wr.y;
			mem_t[wr.addr] <= wr.t;
		end
	end

	always_ff @(posedge clk) begin
		x_q  <= mem_x[rd_addr];
		y_q  <= mem_y[rd_addr];
		rd_t <= mem_t[rd_addr];
	end

	assign rd_x = $signed(x_q);
	assign rd_y = $signed(y_q);

endmodule

@@ rtl/psg_isqrt.sv @@
// ----------------------------------------------------------------------------
// psg_isqrt
// iterative integer square root, one result bit per cycle
// ----------------------------------------------------------------------------
module psg_isqrt (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [psg_pkg::RAD_W-1:0]        radicand,
	output logic [psg_pkg::ROOT_W-1:0]       root,
	output logic                             busy,
	output logic                             done
);

	logic [psg_pkg::RAD_W-1:0] v_q;
	logic [psg_pkg::RAD_W:0]   r_q;
	logic [psg_pkg::RAD_W-1:0] b_q;
	logic                      busy_q;
	logic                      done_q;
	logic [psg_pkg::RAD_W:0]   trial;

	assign trial = r_q + (psg_pkg::RAD_W+1)'(b_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && b_q == psg_pkg::RAD_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q <= radicand;
			r_q <= '0;
			b_q <= psg_pkg::RAD_W'(1) << (2 * (psg_pkg::ROOT_W - 1));
		end else if (busy_q) begin
			if ((psg_pkg::RAD_W+1)'(v_q) >= trial) begin
				v_q <= v_q - trial[psg_pkg::RAD_W-1:0];
				r_q <= (r_q >> 1) + (psg_pkg::RAD_W+1)'(b_q);
			end else begin
				r_q <= r_q >> 1;
			end
			b_q <= b_q >> 2;
		end
	end

	assign root = r_q[psg_pkg::ROOT_W-1:0];
	assign busy = busy_q;
	assign done = done_q;

endmodule

@@ rtl/psg_cordic.sv @@
// ----------------------------------------------------------------------------
// psg_cordic
// iterative cordic vectoring: angle of (xx, yy) in q16 radians after a
// quadrant fold, one rotation step per cycle
// ----------------------------------------------------------------------------
module psg_cordic (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [psg_pkg::V_W-1:0]    yy,
	input  logic signed [psg_pkg::V_W-1:0]    xx,
	output logic signed [psg_pkg::Z_W-1:0]    angle,
	output logic                              done
);

	logic signed [psg_pkg::CR_W-1:0] x_q;
	logic signed [psg_pkg::CR_W-1:0] y_q;
	logic signed [psg_pkg::Z_W-1:0]  z_q;
	logic [psg_pkg::STEP_W-1:0]      step_q;
	logic                            busy_q;
	logic                            done_q;
	logic signed [psg_pkg::CR_W-1:0] xe;
	logic signed [psg_pkg::CR_W-1:0] ye;
	logic signed [psg_pkg::CR_W-1:0] xs;
	logic signed [psg_pkg::CR_W-1:0] ys;
	logic signed [psg_pkg::Z_W-1:0]  at;

	assign xe = psg_pkg::CR_W'(xx);
	assign ye = psg_pkg::CR_W'(yy);
	assign xs = x_q >>> step_q;
	assign ys = y_q >>> step_q;
	assign at = $signed(psg_pkg::atan_q16(step_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				if (xx == '0 && yy == '0) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
				end
			end else if (busy_q && step_q == psg_pkg::STEP_W'(psg_pkg::CORDIC_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			step_q <= '0;
			if (xx == '0 && yy == '0) begin
				x_q <= xe;
				y_q <= ye;
				z_q <= '0;
			end else if (xx < 0) begin
				if (yy >= 0) begin
					x_q <= ye;
					y_q <= -xe;
					z_q <= psg_pkg::Z_W'(psg_pkg::ANG_HALF_PI);
				end else begin
					x_q <= -ye;
					y_q <= xe;
					z_q <= -psg_pkg::Z_W'(psg_pkg::ANG_HALF_PI);
				end
			end else begin
				x_q <= xe;
				y_q <= ye;
				z_q <= '0;
			end
		end else if (busy_q) begin
			step_q <= step_q + psg_pkg::STEP_W'(1);
			if (y_q > 0) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end
		end
	end

	assign angle = z_q;
	assign done  = done_q;

endmodule

@@ rtl/pointer_shake_gesture_detector.sv @@
// ----------------------------------------------------------------------------
// pointer_shake_gesture_detector
// Takes pointer samples and decay ticks, keeps an age and count bounded
// window of samples, tests each new sample for rapid reversals or a
// circular path and raises or lowers a cursor size level.
// ----------------------------------------------------------------------------
// One request at a time; in_ready is high only while idle. A decay tick goes
// straight to the level update. A sample first evicts aged entries, then walks
// every window point; each circle segment uses the shared 17x17 multiplier, a
// length check, the bit-serial square root and the cordic unit (a segment
// shorter than 4 pixels skips the last two), then the closing distance, final
// compares and level update follow. The window holds up to 96 points. The
// update also waits while the previous result has not been taken.
// The result then sits in an output register until taken.
`include "assert_macros.svh"

module pointer_shake_gesture_detector (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               opcode,
	input  logic signed [psg_pkg::POS_W-1:0]   x_position,
	input  logic signed [psg_pkg::POS_W-1:0]   y_position,
	input  logic [psg_pkg::TIME_W-1:0]         time_ms,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [psg_pkg::LEVEL_W-1:0]        size_level,
	output logic [psg_pkg::SIZE_W-1:0]         cursor_size,
	output logic                               grew,
	output logic                               shrank,
	output logic                               reversal_hit,
	output logic                               circle_hit,
	input  logic                               cfg_we,
	input  logic [psg_pkg::IDX_W-1:0]          cfg_index,
	input  logic [psg_pkg::CFG_W-1:0]          cfg_data
);

	psg_pkg::state_t state_q, state_d;

	logic [psg_pkg::CFG_W-1:0]  window_ms_q, cooldown_q, decay_q, min_path_q;
	logic [psg_pkg::SIZE_W-1:0] size_one_q, size_two_q, size_three_q, size_four_q;

	logic [psg_pkg::AW-1:0]      head_q;
	logic [psg_pkg::CNT_W-1:0]   count_q;
	logic [psg_pkg::LEVEL_W-1:0] level_q;
	logic [psg_pkg::TIME_W-1:0]  last_move_q, last_det_q, stamp_q;
	logic                        op_q;

	logic [psg_pkg::CNT_W-1:0]        k_q;
	logic signed [psg_pkg::POS_W-1:0] p1x_q, p1y_q, p2x_q, p2y_q, fx_q, fy_q;
	logic signed [psg_pkg::POS_W-1:0] lox_q, hix_q, loy_q, hiy_q;
	logic signed [psg_pkg::D_W-1:0]   ux_q, uy_q, vx_q, vy_q;
	logic signed [psg_pkg::P_W-1:0]   prod_q;
	logic signed [psg_pkg::V_W-1:0]   uu_q, vv_q, cr_q, dt_q;
	logic [psg_pkg::MC_W-1:0]         mc_q;
	logic                             shift_mode_q;

	logic [psg_pkg::CNT_W-1:0]        flips_q, ccount_q, agree_q;
	logic                             have_prev_q, prev_pos_q, have_hand_q, hand_pos_q;
	logic [psg_pkg::RTRIP_W-1:0]      rtrip_q;
	logic [psg_pkg::CTRIP_W-1:0]      ctrip_q;
	logic [psg_pkg::ROOT_W-1:0]       shift_q;
	logic signed [psg_pkg::NET_W-1:0] net_q;
	logic [psg_pkg::NET_W-1:0]        gross_q;
	logic                             part_q, rh_q, ch_q;

	logic                        out_valid_q;
	logic [psg_pkg::LEVEL_W-1:0] out_level_q;
	logic [psg_pkg::SIZE_W-1:0]  out_size_q;
	logic                        out_grew_q, out_shrank_q, out_rh_q, out_ch_q;

	psg_pkg::store_wr_t               wr;
	logic [psg_pkg::AW-1:0]           rd_addr;
	logic signed [psg_pkg::POS_W-1:0] st_x, st_y;
	logic [psg_pkg::TIME_W-1:0]       st_t;

	logic                             sq_start, sq_busy, sq_done;
	logic [psg_pkg::ROOT_W-1:0]       sq_root;
	logic                             cr_start, cr_done;
	logic signed [psg_pkg::Z_W-1:0]   cr_angle;

	logic in_acc, out_free, evict_hit, seg_short, last_pt, full;
	logic signed [psg_pkg::D_W-1:0] dxs, dys, ma, mb;
	logic [psg_pkg::D_W-1:0]        ax, ay, big, sml;
	logic                           rev_skip, dir_pos;
	logic [psg_pkg::Z_W-1:0]        ang_abs;
	logic                           turn_ok;
	logic [psg_pkg::NET_W-1:0]      net_abs;
	logic [psg_pkg::LEVEL_W-1:0]    lvl_new;
	logic                           do_grow, do_shrink;
	logic [psg_pkg::SIZE_W-1:0]     size_sel;
	logic [psg_pkg::NET_W+6:0]      net100, gross62;
	logic [psg_pkg::CNT_W+3:0]      agree10, count7;
	logic [psg_pkg::CTRIP_W+6:0]    shift100, trip78;
	logic signed [psg_pkg::POS_W:0] span_x, span_y;

	psg_store u_store (
		.clk     (clk),
		.wr      (wr),
		.rd_addr (rd_addr),
		.rd_x    (st_x),
		.rd_y    (st_y),
		.rd_t    (st_t)
	);

	psg_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand ({vv_q[psg_pkg::RAD_W-psg_pkg::SQ_FRAC-1:0], psg_pkg::SQ_FRAC'(0)}),
		.root     (sq_root),
		.busy     (sq_busy),
		.done     (sq_done)
	);

	psg_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cr_start),
		.yy     (cr_q),
		.xx     (dt_q),
		.angle  (cr_angle),
		.done   (cr_done)
	);

	assign in_acc    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign full      = count_q == psg_pkg::DEPTH_CNT;
	assign evict_hit = (stamp_q - st_t) > psg_pkg::TIME_W'(window_ms_q);
	assign seg_short = uu_q < psg_pkg::V_W'(psg_pkg::MIN_SEG_SQ)
		|| vv_q < psg_pkg::V_W'(psg_pkg::MIN_SEG_SQ);
	assign last_pt   = k_q == count_q - psg_pkg::CNT_W'(1);

	// reversal step on the segment ending at the point just read
	assign dxs      = psg_pkg::D_W'(st_x) - psg_pkg::D_W'(p1x_q);
	assign dys      = psg_pkg::D_W'(st_y) - psg_pkg::D_W'(p1y_q);
	assign ax       = (dxs < 0) ? -dxs : dxs;
	assign ay       = (dys < 0) ? -dys : dys;
	assign big      = (ax > ay) ? ax : ay;
	assign sml      = (ax > ay) ? ay : ax;
	assign rev_skip = big < psg_pkg::D_W'(psg_pkg::MIN_BIG)
		|| ((psg_pkg::D_W+3)'(big) << 2) < (psg_pkg::D_W+3)'(sml) * (psg_pkg::D_W+3)'(5);
	assign dir_pos  = (ax >= ay) ? (dxs > 0) : (dys > 0);

	assign ang_abs = (cr_angle < 0) ? -cr_angle : cr_angle;
	assign turn_ok = ang_abs >= psg_pkg::Z_W'(psg_pkg::ANG_MIN_TURN);
	assign net_abs = (net_q < 0) ? -net_q : net_q;

	assign net100   = (psg_pkg::NET_W+7)'(net_abs) * (psg_pkg::NET_W+7)'(100);
	assign gross62  = (psg_pkg::NET_W+7)'(gross_q) * (psg_pkg::NET_W+7)'(62);
	assign agree10  = (psg_pkg::CNT_W+4)'(agree_q) * (psg_pkg::CNT_W+4)'(10);
	assign count7   = (psg_pkg::CNT_W+4)'(ccount_q) * (psg_pkg::CNT_W+4)'(7);
	assign shift100 = (psg_pkg::CTRIP_W+7)'(shift_q) * (psg_pkg::CTRIP_W+7)'(100);
	assign trip78   = (psg_pkg::CTRIP_W+7)'(ctrip_q) * (psg_pkg::CTRIP_W+7)'(78);
	assign span_x   = (psg_pkg::POS_W+1)'(hix_q) - (psg_pkg::POS_W+1)'(lox_q);
	assign span_y   = (psg_pkg::POS_W+1)'(hiy_q) - (psg_pkg::POS_W+1)'(loy_q);

	// level update
	assign do_grow   = (op_q == psg_pkg::OP_SAMPLE) && (rh_q || ch_q)
		&& (stamp_q - last_det_q) >= psg_pkg::TIME_W'(cooldown_q)
		&& level_q < psg_pkg::LEVEL_MAX;
	assign do_shrink = (op_q == psg_pkg::OP_TICK) && level_q != '0
		&& (stamp_q - last_move_q) >= psg_pkg::TIME_W'(decay_q);
	assign lvl_new   = do_grow ? level_q + psg_pkg::LEVEL_W'(1)
		: do_shrink ? level_q - psg_pkg::LEVEL_W'(1) : level_q;

	always_comb begin
		case (lvl_new)
			3'd1:    size_sel = size_one_q;
			3'd2:    size_sel = size_two_q;
			3'd3:    size_sel = size_three_q;
			3'd4:    size_sel = size_four_q;
			default: size_sel = '0;
		endcase
	end

	// shared multiplier operands
	always_comb begin
		case (mc_q)
			4'd0:    begin ma = ux_q; mb = ux_q; end
			4'd1:    begin ma = uy_q; mb = uy_q; end
			4'd2:    begin ma = vx_q; mb = vx_q; end
			4'd3:    begin ma = vy_q; mb = vy_q; end
			4'd4:    begin ma = ux_q; mb = vy_q; end
			4'd5:    begin ma = uy_q; mb = vx_q; end
			4'd6:    begin ma = ux_q; mb = vx_q; end
			default: begin ma = uy_q; mb = vy_q; end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			psg_pkg::S_IDLE: begin
				if (in_acc) begin
					state_d = (opcode == psg_pkg::OP_TICK) ? psg_pkg::S_UPD : psg_pkg::S_EVICT_RD;
				end
			end
			psg_pkg::S_EVICT_RD:  state_d = psg_pkg::S_EVICT_CHK;
			psg_pkg::S_EVICT_CHK: state_d = evict_hit ? psg_pkg::S_EVICT_RD : psg_pkg::S_PT_RD;
			psg_pkg::S_PT_RD:     state_d = psg_pkg::S_PT_GET;
			psg_pkg::S_PT_GET: begin
				state_d = (k_q >= psg_pkg::CNT_W'(2)) ? psg_pkg::S_MUL : psg_pkg::S_NEXT;
			end
			psg_pkg::S_NEXT:      state_d = last_pt ? psg_pkg::S_MUL : psg_pkg::S_PT_RD;
			psg_pkg::S_MUL: begin
				if (mc_q == psg_pkg::MC_W'(psg_pkg::MUL_LAST)) begin
					state_d = psg_pkg::S_CHK;
				end
			end
			psg_pkg::S_CHK: begin
				state_d = (!shift_mode_q && seg_short) ? psg_pkg::S_NEXT : psg_pkg::S_SQW;
			end
			psg_pkg::S_SQW: begin
				if (sq_done) begin
					state_d = shift_mode_q ? psg_pkg::S_FIN1 : psg_pkg::S_CRW;
				end
			end
			psg_pkg::S_CRW: begin
				if (cr_done) begin
					state_d = psg_pkg::S_NEXT;
				end
			end
			psg_pkg::S_FIN1: state_d = psg_pkg::S_FIN2;
			psg_pkg::S_FIN2: state_d = psg_pkg::S_UPD;
			psg_pkg::S_UPD: begin
				if (out_free) begin
					state_d = psg_pkg::S_IDLE;
				end
			end
			default: state_d = psg_pkg::S_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_ready = 1'b0;
		rd_addr  = head_q;
		sq_start = 1'b0;
		cr_start = 1'b0;
		wr.we    = 1'b0;
		wr.addr  = full ? head_q : psg_pkg::slot_add(head_q, count_q);
		wr.x     = psg_pkg::coord_ext(x_position);
		wr.y     = psg_pkg::coord_ext(y_position);
		wr.t     = time_ms;
		case (state_q)
			psg_pkg::S_IDLE: begin
				in_ready = 1'b1;
				wr.we    = in_valid && (opcode == psg_pkg::OP_SAMPLE);
			end
			psg_pkg::S_EVICT_RD: rd_addr = head_q;
			psg_pkg::S_PT_RD:    rd_addr = psg_pkg::slot_add(head_q, k_q);
			psg_pkg::S_CHK:      sq_start = shift_mode_q || !seg_short;
			psg_pkg::S_SQW:      cr_start = sq_done && !shift_mode_q;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= psg_pkg::S_IDLE;
			window_ms_q  <= psg_pkg::CFG_W'(900);
			cooldown_q   <= psg_pkg::CFG_W'(280);
			decay_q      <= psg_pkg::CFG_W'(300);
			min_path_q   <= psg_pkg::CFG_W'(260);
			size_one_q   <= psg_pkg::SIZE_W'(48);
			size_two_q   <= psg_pkg::SIZE_W'(64);
			size_three_q <= psg_pkg::SIZE_W'(80);
			size_four_q  <= psg_pkg::SIZE_W'(96);
			head_q       <= '0;
			count_q      <= '0;
			level_q      <= '0;
			last_move_q  <= '0;
			last_det_q   <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (psg_pkg::cfg_reg_t'(cfg_index))
					psg_pkg::REG_WINDOW_MS:   window_ms_q  <= cfg_data;
					psg_pkg::REG_COOLDOWN_MS: cooldown_q   <= cfg_data;
					psg_pkg::REG_DECAY_MS:    decay_q      <= cfg_data;
					psg_pkg::REG_MIN_PATH:    min_path_q   <= cfg_data;
					psg_pkg::REG_SIZE_ONE:    size_one_q   <= cfg_data[psg_pkg::SIZE_W-1:0];
					psg_pkg::REG_SIZE_TWO:    size_two_q   <= cfg_data[psg_pkg::SIZE_W-1:0];
					psg_pkg::REG_SIZE_THREE:  size_three_q <= cfg_data[psg_pkg::SIZE_W-1:0];
					psg_pkg::REG_SIZE_FOUR:   size_four_q  <= cfg_data[psg_pkg::SIZE_W-1:0];
					default: begin
					end
				endcase
			end
			if (out_valid_q && out_ready && state_q != psg_pkg::S_UPD) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				psg_pkg::S_IDLE: begin
					if (in_acc && opcode == psg_pkg::OP_SAMPLE) begin
						last_move_q <= time_ms;
						if (full) begin
							head_q <= psg_pkg::slot_inc(head_q);
						end else begin
							count_q <= count_q + psg_pkg::CNT_W'(1);
						end
					end
				end
				psg_pkg::S_EVICT_CHK: begin
					if (evict_hit) begin
						head_q  <= psg_pkg::slot_inc(head_q);
						count_q <= count_q - psg_pkg::CNT_W'(1);
					end
				end
				psg_pkg::S_UPD: begin
					if (out_free) begin
						level_q      <= lvl_new;
						out_valid_q  <= 1'b1;
						if (do_grow) begin
							last_det_q <= stamp_q;
						end
						if (do_shrink) begin
							count_q <= '0;
						end
					end else if (out_valid_q && out_ready) begin
						out_valid_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			psg_pkg::S_IDLE: begin
				if (in_acc) begin
					op_q    <= opcode;
					stamp_q <= time_ms;
					rh_q    <= 1'b0;
					ch_q    <= 1'b0;
				end
			end
			psg_pkg::S_EVICT_CHK: begin
				k_q          <= '0;
				flips_q      <= '0;
				ccount_q     <= '0;
				agree_q      <= '0;
				have_prev_q  <= 1'b0;
				have_hand_q  <= 1'b0;
				rtrip_q      <= '0;
				ctrip_q      <= '0;
				net_q        <= '0;
				gross_q      <= '0;
				shift_mode_q <= 1'b0;
			end
			psg_pkg::S_PT_GET: begin
				if (k_q == '0) begin
					fx_q  <= st_x;
					fy_q  <= st_y;
					lox_q <= st_x;
					hix_q <= st_x;
					loy_q <= st_y;
					hiy_q <= st_y;
				end else begin
					if (st_x < lox_q) lox_q <= st_x;
					if (st_x > hix_q) hix_q <= st_x;
					if (st_y < loy_q) loy_q <= st_y;
					if (st_y > hiy_q) hiy_q <= st_y;
					if (!rev_skip) begin
						rtrip_q     <= rtrip_q + psg_pkg::RTRIP_W'(big);
						have_prev_q <= 1'b1;
						prev_pos_q  <= dir_pos;
						if (have_prev_q && dir_pos != prev_pos_q) begin
							flips_q <= flips_q + psg_pkg::CNT_W'(1);
						end
					end
				end
				ux_q  <= psg_pkg::D_W'(p1x_q) - psg_pkg::D_W'(p2x_q);
				uy_q  <= psg_pkg::D_W'(p1y_q) - psg_pkg::D_W'(p2y_q);
				vx_q  <= dxs;
				vy_q  <= dys;
				mc_q  <= '0;
				p2x_q <= p1x_q;
				p2y_q <= p1y_q;
				p1x_q <= st_x;
				p1y_q <= st_y;
			end
			psg_pkg::S_NEXT: begin
				if (last_pt) begin
					shift_mode_q <= 1'b1;
					vx_q         <= psg_pkg::D_W'(p1x_q) - psg_pkg::D_W'(fx_q);
					vy_q         <= psg_pkg::D_W'(p1y_q) - psg_pkg::D_W'(fy_q);
					mc_q         <= '0;
				end else begin
					k_q <= k_q + psg_pkg::CNT_W'(1);
				end
			end
			psg_pkg::S_MUL: begin
				mc_q   <= mc_q + psg_pkg::MC_W'(1);
				prod_q <= ma * mb;
				case (mc_q)
					4'd1:    uu_q <= psg_pkg::V_W'(prod_q);
					4'd2:    uu_q <= uu_q + psg_pkg::V_W'(prod_q);
					4'd3:    vv_q <= psg_pkg::V_W'(prod_q);
					4'd4:    vv_q <= vv_q + psg_pkg::V_W'(prod_q);
					4'd5:    cr_q <= psg_pkg::V_W'(prod_q);
					4'd6:    cr_q <= cr_q - psg_pkg::V_W'(prod_q);
					4'd7:    dt_q <= psg_pkg::V_W'(prod_q);
					4'd8:    dt_q <= dt_q + psg_pkg::V_W'(prod_q);
					default: begin
					end
				endcase
			end
			psg_pkg::S_SQW: begin
				if (sq_done) begin
					if (shift_mode_q) begin
						shift_q <= sq_root;
					end else begin
						ctrip_q <= ctrip_q + psg_pkg::CTRIP_W'(sq_root);
					end
				end
			end
			psg_pkg::S_CRW: begin
				if (cr_done && turn_ok) begin
					net_q       <= net_q + psg_pkg::NET_W'(cr_angle);
					gross_q     <= gross_q + psg_pkg::NET_W'(ang_abs);
					ccount_q    <= ccount_q + psg_pkg::CNT_W'(1);
					have_hand_q <= 1'b1;
					hand_pos_q  <= cr_angle > 0;
					if (!have_hand_q || (cr_angle > 0) == hand_pos_q) begin
						agree_q <= agree_q + psg_pkg::CNT_W'(1);
					end
				end
			end
			psg_pkg::S_FIN1: begin
				part_q <= count_q >= psg_pkg::CNT_W'(psg_pkg::CIRC_MIN_COUNT)
					&& ctrip_q >= (psg_pkg::CTRIP_W'(min_path_q) << 8)
					&& ccount_q >= psg_pkg::CNT_W'(psg_pkg::MIN_TURNS)
					&& span_x >= (psg_pkg::POS_W+1)'(psg_pkg::SPAN_MIN)
					&& span_y >= (psg_pkg::POS_W+1)'(psg_pkg::SPAN_MIN)
					&& net_abs >= psg_pkg::NET_W'(psg_pkg::ANG_ARC_NEEDED);
			end
			psg_pkg::S_FIN2: begin
				ch_q <= part_q && gross_q != '0 && net100 >= gross62
					&& agree10 >= count7 && shift100 < trip78;
				rh_q <= count_q >= psg_pkg::CNT_W'(psg_pkg::REV_MIN_COUNT)
					&& flips_q >= psg_pkg::CNT_W'(psg_pkg::MIN_FLIPS)
					&& rtrip_q >= psg_pkg::RTRIP_W'(min_path_q);
			end
			psg_pkg::S_UPD: begin
				if (out_free) begin
					out_level_q  <= lvl_new;
					out_size_q   <= size_sel;
					out_grew_q   <= do_grow;
					out_shrank_q <= do_shrink;
					out_rh_q     <= rh_q;
					out_ch_q     <= ch_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid    = out_valid_q;
	assign size_level   = out_level_q;
	assign cursor_size  = out_size_q;
	assign grew         = out_grew_q;
	assign shrank       = out_shrank_q;
	assign reversal_hit = out_rh_q;
	assign circle_hit   = out_ch_q;

	`PSG_ASSERT(a_count_bound, clk, arst_n, count_q <= psg_pkg::DEPTH_CNT, "window count over depth")
	`PSG_ASSERT(a_level_bound, clk, arst_n, level_q <= psg_pkg::LEVEL_MAX, "level above four")
	`PSG_ASSERT(a_pass_nonempty, clk, arst_n, (state_q != psg_pkg::S_PT_RD) || (count_q != '0), "walk over empty window")
	`PSG_ASSERT(a_sqrt_idle, clk, arst_n, !sq_start || !sq_busy, "sqrt restarted while busy")
	`PSG_ASSERT_NEXT(a_result_loaded, clk, arst_n, state_q == psg_pkg::S_UPD && out_free, out_valid_q, "result not loaded")

endmodule
